@@ hw/rtl/tws_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Three-wire serial transfer engine package
// Shared types and constants for the front queue and the transfer engine.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeStart = 2'd1;
  localparam logic [1:0] ModeLoad  = 2'd2;

  localparam logic [7:0] CmdSend = 8'h01;
  localparam logic [7:0] CmdRecv = 8'h02;
  localparam logic [1:0] HdrLast = 2'd2;
  localparam logic [2:0] BitLast = 3'd7;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_START,
    OP_LOAD,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_TXDATA,
    PH_RXDATA,
    PH_TRAIL
  } phase_e;

  typedef struct packed {
    op_e         op;
    logic        direction;
    logic [15:0] length;
    logic [7:0]  tx_byte;
    logic        sck;
    logic        data_in;
  } item_t;

endpackage
`default_nettype wire

@@ hw/rtl/tws_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts input items, decodes the mode into an operation and holds them in
// a short queue for the transfer engine.
// ----------------------------------------------------------------------------
module tws_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [1:0]    mode_i,
  input  wire logic          direction_i,
  input  wire logic [15:0]   length_i,
  input  wire logic [7:0]    tx_byte_i,
  input  wire logic          sck_i,
  input  wire logic          data_in_i,
  output logic               q_valid_o,
  output tws_pkg::item_t     q_item_o,
  input  wire logic          pop_i
);

  tws_pkg::item_t                  mem_q [tws_pkg::QDepth];
  tws_pkg::item_t                  item;
  logic [tws_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [tws_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [tws_pkg::QCntW-1:0]       count_q, count_d;
  logic                            push;

  always_comb begin
    item.direction = direction_i;
    item.length    = length_i;
    item.tx_byte   = tx_byte_i;
    item.sck       = sck_i;
    item.data_in   = data_in_i;
    case (mode_i)
      tws_pkg::ModeTick:  item.op = tws_pkg::OP_TICK;
      tws_pkg::ModeStart: item.op = tws_pkg::OP_START;
      tws_pkg::ModeLoad:  item.op = tws_pkg::OP_LOAD;
      default:            item.op = tws_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o = (count_q == tws_pkg::QCntW'(tws_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/tws_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Transfer engine
// Executes queued items against the link state (header, send data, receive
// data, trailing cycle) and registers one result per item.
// ----------------------------------------------------------------------------
module tws_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire tws_pkg::item_t q_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               cs_n_o,
  output logic               data_out_o,
  output logic               data_drive_o,
  output logic [7:0]         rx_byte_o,
  output logic               rx_valid_o,
  output logic               tx_request_o,
  output logic               tx_underrun_o,
  output logic               busy_res_o,
  output logic               done_res_o
);

  tws_pkg::phase_e phase_q, phase_d;
  logic [7:0]      shift_q, shift_d;
  logic [2:0]      bit_q, bit_d;
  logic [15:0]     left_q, left_d;
  logic [1:0]      hdr_q, hdr_d;
  logic            seen_q, seen_d;
  logic            dir_q, dir_d;
  logic [7:0]      hold_q, hold_d;
  logic            full_q, full_d;

  logic            fire;
  logic            rx_valid, underrun, done;
  logic [7:0]      rx_byte;

  logic            cs_n, data_out, data_drive, tx_req, busy;
  logic            out_valid_q;
  logic            cs_n_q, data_out_q, data_drive_q, rx_valid_q;
  logic            tx_req_q, underrun_q, busy_q, done_q;
  logic [7:0]      rx_byte_q;

  assign fire  = q_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  // next state
  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    bit_d    = bit_q;
    left_d   = left_q;
    hdr_d    = hdr_q;
    seen_d   = seen_q;
    dir_d    = dir_q;
    hold_d   = hold_q;
    full_d   = full_q;
    rx_valid = 1'b0;
    rx_byte  = '0;
    underrun = 1'b0;
    done     = 1'b0;
    if (fire) begin
      case (q_item_i.op)
        tws_pkg::OP_START: begin
          if (phase_q == tws_pkg::PH_IDLE) begin
            dir_d   = q_item_i.direction;
            left_d  = q_item_i.length;
            hdr_d   = '0;
            bit_d   = '0;
            seen_d  = 1'b0;
            shift_d = q_item_i.direction ? tws_pkg::CmdRecv : tws_pkg::CmdSend;
            phase_d = tws_pkg::PH_HEADER;
          end
        end
        tws_pkg::OP_LOAD: begin
          hold_d = q_item_i.tx_byte;
          full_d = 1'b1;
        end
        tws_pkg::OP_TICK: begin
          if (phase_q != tws_pkg::PH_IDLE) begin
            if (!seen_q) begin
              if (q_item_i.sck) begin
                seen_d = 1'b1;
                if (phase_q == tws_pkg::PH_RXDATA) begin
                  shift_d = {shift_q[6:0], q_item_i.data_in};
                end
              end
            end else if (!q_item_i.sck) begin
              seen_d = 1'b0;
              if (phase_q == tws_pkg::PH_TRAIL) begin
                phase_d = tws_pkg::PH_IDLE;
                done    = 1'b1;
              end else begin
                bit_d = bit_q + 1'b1;
                if (phase_q != tws_pkg::PH_RXDATA) begin
                  shift_d = {shift_q[6:0], 1'b0};
                end
                if (bit_q == tws_pkg::BitLast) begin
                  if (phase_q == tws_pkg::PH_RXDATA) begin
                    rx_valid = 1'b1;
                    rx_byte  = shift_q;
                    shift_d  = '0;
                    left_d   = left_q - 1'b1;
                    if (left_q == 16'd1) begin
                      phase_d = tws_pkg::PH_TRAIL;
                    end
                  end else if (phase_q == tws_pkg::PH_HEADER && hdr_q < tws_pkg::HdrLast) begin
                    hdr_d   = hdr_q + 1'b1;
                    shift_d = (hdr_q == 2'd0) ? left_q[15:8] : left_q[7:0];
                  end else if (phase_q == tws_pkg::PH_HEADER && dir_q) begin
                    shift_d = '0;
                    phase_d = (left_q == '0) ? tws_pkg::PH_TRAIL : tws_pkg::PH_RXDATA;
                  end else if (left_q == '0) begin
                    phase_d = tws_pkg::PH_TRAIL;
                    shift_d = '0;
                  end else begin
                    left_d  = left_q - 1'b1;
                    phase_d = tws_pkg::PH_TXDATA;
                    if (full_q) begin
                      shift_d = hold_q;
                      full_d  = 1'b0;
                    end else begin
                      shift_d  = '0;
                      underrun = 1'b1;
                    end
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // outputs, from the state after the item
  always_comb begin
    cs_n       = 1'b1;
    data_out   = 1'b0;
    data_drive = 1'b1;
    tx_req     = 1'b0;
    busy       = 1'b1;
    case (phase_d)
      tws_pkg::PH_HEADER, tws_pkg::PH_TXDATA: begin
        cs_n     = 1'b0;
        data_out = shift_d[7];
        tx_req   = !dir_d && (left_d != '0) && !full_d;
      end
      tws_pkg::PH_RXDATA: begin
        cs_n       = 1'b0;
        data_drive = 1'b0;
      end
      tws_pkg::PH_TRAIL: begin
        data_drive = !dir_d;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tws_pkg::PH_IDLE;
      shift_q     <= '0;
      bit_q       <= '0;
      left_q      <= '0;
      hdr_q       <= '0;
      seen_q      <= 1'b0;
      dir_q       <= 1'b0;
      hold_q      <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bit_q   <= bit_d;
      left_q  <= left_d;
      hdr_q   <= hdr_d;
      seen_q  <= seen_d;
      dir_q   <= dir_d;
      hold_q  <= hold_d;
      full_q  <= full_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cs_n_q       <= cs_n;
      data_out_q   <= data_out;
      data_drive_q <= data_drive;
      rx_byte_q    <= rx_byte;
      rx_valid_q   <= rx_valid;
      tx_req_q     <= tx_req;
      underrun_q   <= underrun;
      busy_q       <= busy;
      done_q       <= done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cs_n_o        = cs_n_q;
  assign data_out_o    = data_out_q;
  assign data_drive_o  = data_drive_q;
  assign rx_byte_o     = rx_byte_q;
  assign rx_valid_o    = rx_valid_q;
  assign tx_request_o  = tx_req_q;
  assign tx_underrun_o = underrun_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;

`ifndef SYNTH
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && done) |=> phase_q == tws_pkg::PH_IDLE)
    else $error("done without return to idle");
  a_rx_in_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && rx_valid) |-> phase_q == tws_pkg::PH_RXDATA && dir_q)
    else $error("rx byte outside receive data");
  a_underrun_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && underrun) |-> !dir_q && !full_q)
    else $error("underrun outside send or with full holding register");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/three_wire_serial_transfer_engine_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Three-wire serial transfer engine
// Partner-clocked three-wire transfer engine: header, send or receive data,
// trailing clock cycle.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle when not stalled: pin sample ticks,
// start and load items pass through a two-entry queue into the engine, which
// handles one item per cycle unless its output is stalled and registers its
// result. With out_stall_i low, an item is written into the queue and its
// result then registered on the outputs; input stall rises only once the queue
// is full, with items back to back right after the first stalled output cycle.
module three_wire_serial_transfer_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic        direction_i,
  input  wire logic [15:0] length_i,
  input  wire logic [7:0]  tx_byte_i,
  input  wire logic        sck_i,
  input  wire logic        data_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             cs_n_o,
  output logic             data_out_o,
  output logic             data_drive_o,
  output logic [7:0]       rx_byte_o,
  output logic             rx_valid_o,
  output logic             tx_request_o,
  output logic             tx_underrun_o,
  output logic             busy_res_o,
  output logic             done_res_o
);

  logic           q_valid;
  tws_pkg::item_t q_item;
  logic           pop;

  tws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .direction_i (direction_i),
    .length_i    (length_i),
    .tx_byte_i   (tx_byte_i),
    .sck_i       (sck_i),
    .data_in_i   (data_in_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .pop_i       (pop)
  );

  tws_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cs_n_o        (cs_n_o),
    .data_out_o    (data_out_o),
    .data_drive_o  (data_drive_o),
    .rx_byte_o     (rx_byte_o),
    .rx_valid_o    (rx_valid_o),
    .tx_request_o  (tx_request_o),
    .tx_underrun_o (tx_underrun_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o)
  );

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Three-wire serial transfer engine testbench
// A directed table walks the corner cases: idle traffic, unused op, ignored
// start, zero length, underrun, holding register overwrite and both
// directions. Random partner-clock traffic follows, with bursty input and
// output back-pressure. Every result item is checked, typed table rows against
// their given result, the rest against a cycle-free engine model in this bench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       cs_n;
    logic       data_out;
    logic       data_drive;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       tx_request;
    logic       tx_underrun;
    logic       busy;
    logic       done;
  } result_t;

  typedef struct packed {
    tws_pkg::op_e op;
    logic         dir;
    logic [15:0]  len;
    logic [7:0]   txb;
    logic         sck;
    logic         din;
    logic [7:0]   cycles;
    logic         typed;
    result_t      res;
  } row_t;

  localparam result_t IdleRes = '{cs_n: 1'b1, data_out: 1'b0, data_drive: 1'b1,
                                  rx_byte: 8'h00, rx_valid: 1'b0, tx_request: 1'b0,
                                  tx_underrun: 1'b0, busy: 1'b0, done: 1'b0};
  localparam result_t HdrRes  = '{cs_n: 1'b0, data_out: 1'b0, data_drive: 1'b1,
                                  rx_byte: 8'h00, rx_valid: 1'b0, tx_request: 1'b0,
                                  tx_underrun: 1'b0, busy: 1'b1, done: 1'b0};
  localparam result_t TrailRes = '{cs_n: 1'b1, data_out: 1'b0, data_drive: 1'b1,
                                   rx_byte: 8'h00, rx_valid: 1'b0, tx_request: 1'b0,
                                   tx_underrun: 1'b0, busy: 1'b1, done: 1'b0};
  localparam result_t DoneRes = '{cs_n: 1'b1, data_out: 1'b0, data_drive: 1'b1,
                                  rx_byte: 8'h00, rx_valid: 1'b0, tx_request: 1'b0,
                                  tx_underrun: 1'b0, busy: 1'b0, done: 1'b1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  mode = tws_pkg::OP_TICK;
  logic        direction = 1'b0;
  logic [15:0] length = '0;
  logic [7:0]  tx_byte = '0;
  logic        sck = 1'b0;
  logic        data_in = 1'b0;
  logic        out_stall = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        cs_n_o;
  logic        data_out_o;
  logic        data_drive_o;
  logic [7:0]  rx_byte_o;
  logic        rx_valid_o;
  logic        tx_request_o;
  logic        tx_underrun_o;
  logic        busy_res_o;
  logic        done_res_o;

  three_wire_serial_transfer_engine_top DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode),
    .direction_i  (direction),
    .length_i     (length),
    .tx_byte_i    (tx_byte),
    .sck_i        (sck),
    .data_in_i    (data_in),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .cs_n_o       (cs_n_o),
    .data_out_o   (data_out_o),
    .data_drive_o (data_drive_o),
    .rx_byte_o    (rx_byte_o),
    .rx_valid_o   (rx_valid_o),
    .tx_request_o (tx_request_o),
    .tx_underrun_o(tx_underrun_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o)
  );

  always #5 clk = ~clk;

  // engine state mirror
  tws_pkg::phase_e ph = tws_pkg::PH_IDLE;
  logic [7:0]  shreg = '0;
  logic [2:0]  bit_idx = '0;
  logic [15:0] remaining = '0;
  logic [1:0]  hdr_idx = '0;
  logic        high_seen = 1'b0;
  logic        recv_dir = 1'b0;
  logic [7:0]  hold = '0;
  logic        hold_full = 1'b0;

  result_t     due_results [$];
  result_t     want;
  int          errors = 0;
  int          checked = 0;
  int          work_items = 0;
  int          done_cnt = 0;
  int          rx_cnt = 0;
  int          und_cnt = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  logic        sck_lvl = 1'b0;
  int          sck_hold = 0;

  row_t plan [26] = '{
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b1, 1'b1, 8'd0,  1'b1, IdleRes},
    '{tws_pkg::OP_NOP,   1'b1, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'd0,  1'b1, IdleRes},
    '{tws_pkg::OP_LOAD,  1'b0, 16'h0000, 8'hFF, 1'b0, 1'b0, 8'd0,  1'b1, IdleRes},
    '{tws_pkg::OP_START, 1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 8'd0,  1'b1, HdrRes},
    '{tws_pkg::OP_START, 1'b1, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 8'd0,  1'b1, HdrRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd24, 1'b0, IdleRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b1, 1'b0, 8'd0,  1'b1, TrailRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd0,  1'b1, DoneRes},
    '{tws_pkg::OP_START, 1'b0, 16'h0002, 8'h00, 1'b0, 1'b0, 8'd0,  1'b1, HdrRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd24, 1'b0, IdleRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd8,  1'b0, IdleRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd8,  1'b0, IdleRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd1,  1'b0, IdleRes},
    '{tws_pkg::OP_START, 1'b1, 16'h0002, 8'h00, 1'b0, 1'b0, 8'd0,  1'b1, HdrRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd24, 1'b0, IdleRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b1, 8'd8,  1'b0, IdleRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd8,  1'b0, IdleRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd1,  1'b0, IdleRes},
    '{tws_pkg::OP_LOAD,  1'b0, 16'h0000, 8'h5A, 1'b0, 1'b0, 8'd0,  1'b1, IdleRes},
    '{tws_pkg::OP_LOAD,  1'b0, 16'h0000, 8'hA5, 1'b0, 1'b0, 8'd0,  1'b1, IdleRes},
    '{tws_pkg::OP_START, 1'b0, 16'h0001, 8'h00, 1'b0, 1'b0, 8'd0,  1'b1, HdrRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd24, 1'b0, IdleRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b1, 8'd8,  1'b0, IdleRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd1,  1'b0, IdleRes},
    '{tws_pkg::OP_START, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd0,  1'b1, HdrRes},
    '{tws_pkg::OP_TICK,  1'b0, 16'h0000, 8'h00, 1'b0, 1'b0, 8'd25, 1'b0, IdleRes}
  };

  function automatic logic [7:0] header_byte_at(logic [1:0] idx);
    if (idx == 2'd0) return recv_dir ? tws_pkg::CmdRecv : tws_pkg::CmdSend;
    if (idx == 2'd1) return remaining[15:8];
    return remaining[7:0];
  endfunction

  // returns 1 on underrun
  function automatic logic begin_tx_byte();
    if (remaining == '0) begin
      ph = tws_pkg::PH_TRAIL;
      shreg = '0;
      return 1'b0;
    end
    remaining = remaining - 16'd1;
    ph = tws_pkg::PH_TXDATA;
    if (hold_full) begin
      shreg = hold;
      hold_full = 1'b0;
      return 1'b0;
    end
    shreg = '0;
    return 1'b1;
  endfunction

  function automatic result_t advance_engine(tws_pkg::op_e op, logic dir, logic [15:0] len,
                                             logic [7:0] txb, logic pin_sck, logic din);
    result_t r;
    logic    ends_byte;
    r = '0;
    case (op)
      tws_pkg::OP_START: begin
        if (ph == tws_pkg::PH_IDLE) begin
          recv_dir = dir;
          remaining = len;
          hdr_idx = '0;
          bit_idx = '0;
          high_seen = 1'b0;
          shreg = header_byte_at(2'd0);
          ph = tws_pkg::PH_HEADER;
        end
      end
      tws_pkg::OP_LOAD: begin
        hold = txb;
        hold_full = 1'b1;
      end
      tws_pkg::OP_TICK: begin
        if (ph != tws_pkg::PH_IDLE) begin
          if (!high_seen) begin
            if (pin_sck) begin
              high_seen = 1'b1;
              if (ph == tws_pkg::PH_RXDATA) shreg = {shreg[6:0], din};
            end
          end else if (!pin_sck) begin
            high_seen = 1'b0;
            if (ph == tws_pkg::PH_TRAIL) begin
              ph = tws_pkg::PH_IDLE;
              r.done = 1'b1;
            end else begin
              ends_byte = (bit_idx == tws_pkg::BitLast);
              bit_idx = bit_idx + 3'd1;
              if (ph != tws_pkg::PH_RXDATA) shreg = shreg << 1;
              if (ends_byte) begin
                case (ph)
                  tws_pkg::PH_HEADER: begin
                    if (hdr_idx != tws_pkg::HdrLast) begin
                      hdr_idx = hdr_idx + 2'd1;
                      shreg = header_byte_at(hdr_idx);
                    end else if (recv_dir) begin
                      shreg = '0;
                      ph = (remaining == '0) ? tws_pkg::PH_TRAIL : tws_pkg::PH_RXDATA;
                    end else begin
                      r.tx_underrun = begin_tx_byte();
                    end
                  end
                  tws_pkg::PH_TXDATA: r.tx_underrun = begin_tx_byte();
                  default: begin
                    r.rx_valid = 1'b1;
                    r.rx_byte = shreg;
                    shreg = '0;
                    remaining = remaining - 16'd1;
                    if (remaining == '0) ph = tws_pkg::PH_TRAIL;
                  end
                endcase
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.cs_n = !(ph == tws_pkg::PH_HEADER || ph == tws_pkg::PH_TXDATA ||
               ph == tws_pkg::PH_RXDATA);
    r.data_out = (ph == tws_pkg::PH_HEADER || ph == tws_pkg::PH_TXDATA) && shreg[7];
    r.data_drive = !(ph == tws_pkg::PH_RXDATA || (ph == tws_pkg::PH_TRAIL && recv_dir));
    r.tx_request = (ph == tws_pkg::PH_HEADER || ph == tws_pkg::PH_TXDATA) && !recv_dir &&
                   remaining != '0 && !hold_full;
    r.busy = (ph != tws_pkg::PH_IDLE);
    return r;
  endfunction

  task automatic push_item(tws_pkg::op_e op, logic dir, logic [15:0] len, logic [7:0] txb,
                           logic pin_sck, logic din, logic typed, result_t typed_res);
    result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid  <= 1'b1;
    mode      <= op;
    direction <= dir;
    length    <= len;
    tx_byte   <= txb;
    sck       <= pin_sck;
    data_in   <= din;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    if (op == tws_pkg::OP_LOAD || (op == tws_pkg::OP_START && ph == tws_pkg::PH_IDLE) ||
        (op == tws_pkg::OP_TICK && ph != tws_pkg::PH_IDLE)) work_items++;
    r = advance_engine(op, dir, len, txb, pin_sck, din);
    due_results.push_back(typed ? typed_res : r);
    done_cnt += r.done;
    rx_cnt   += r.rx_valid;
    und_cnt  += r.tx_underrun;
  endtask

  task automatic clock_bits(int n, logic din);
    repeat (n) begin
      push_item(tws_pkg::OP_TICK, 1'($urandom), 16'($urandom), 8'($urandom), 1'b1, din,
                1'b0, '0);
      push_item(tws_pkg::OP_TICK, 1'($urandom), 16'($urandom), 8'($urandom), 1'b0, din,
                1'b0, '0);
    end
  endtask

  task automatic partner_tick();
    if (sck_hold == 0) begin
      sck_lvl = !sck_lvl;
      sck_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 2);
    end
    sck_hold--;
    push_item(tws_pkg::OP_TICK, 1'($urandom), 16'($urandom), 8'($urandom), sck_lvl,
              1'($urandom), 1'b0, '0);
  endtask

  task automatic push_random(tws_pkg::op_e op);
    push_item(op, 1'($urandom), 16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
              1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want_v,
                           input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(10, 80);
        end
        1: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(1, 10);
        end
        default: begin
          out_stall  <= 1'($urandom_range(0, 1));
          stall_left <= $urandom_range(1, 3);
        end
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (out_valid_o === 1'b1 && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result item arrived with nothing outstanding");
        errors++;
      end else begin
        want = due_results.pop_front();
        checked++;
        cmp_field("cs_n", 8'(want.cs_n), 8'(cs_n_o));
        cmp_field("data_out", 8'(want.data_out), 8'(data_out_o));
        cmp_field("data_drive", 8'(want.data_drive), 8'(data_drive_o));
        cmp_field("rx_byte", want.rx_byte, rx_byte_o);
        cmp_field("rx_valid", 8'(want.rx_valid), 8'(rx_valid_o));
        cmp_field("tx_request", 8'(want.tx_request), 8'(tx_request_o));
        cmp_field("tx_underrun", 8'(want.tx_underrun), 8'(tx_underrun_o));
        cmp_field("busy_res", 8'(want.busy), 8'(busy_res_o));
        cmp_field("done_res", 8'(want.done), 8'(done_res_o));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("three_wire_serial_transfer_engine_top regression: fail");
    $finish;
  end

  initial begin
    int unsigned pick;
    logic [15:0] len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cycles != 0) begin
        clock_bits(plan[i].cycles, plan[i].din);
      end else begin
        push_item(plan[i].op, plan[i].dir, plan[i].len, plan[i].txb, plan[i].sck,
                  plan[i].din, plan[i].typed, plan[i].res);
      end
    end
    drain();

    while (work_items < 1500) begin
      if (ph == tws_pkg::PH_IDLE) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          push_random(tws_pkg::OP_NOP);
        end else if (pick < 3) begin
          partner_tick();
        end else if (pick < 5) begin
          push_random(tws_pkg::OP_LOAD);
        end else begin
          case ($urandom_range(0, 9))
            0, 1:    len = '0;
            8, 9:    len = 16'($urandom_range(4, 12));
            default: len = 16'($urandom_range(1, 3));
          endcase
          push_item(tws_pkg::OP_START, 1'($urandom), len, 8'($urandom), 1'($urandom),
                    1'($urandom), 1'b0, '0);
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (!recv_dir && !hold_full && remaining != '0 && pick < 10) begin
          push_random(tws_pkg::OP_LOAD);
        end else if (pick < 2) begin
          push_random(tws_pkg::OP_START);
        end else if (pick < 4) begin
          push_random(tws_pkg::OP_NOP);
        end else if (pick < 6) begin
          push_random(tws_pkg::OP_LOAD);
        end else begin
          partner_tick();
        end
      end
      if ($urandom_range(0, 199) == 0) drain();
    end

    // finish the open transfer, then run a full-length header
    while (ph != tws_pkg::PH_IDLE) partner_tick();
    drain();
    push_item(tws_pkg::OP_START, 1'($urandom), 16'hFFFF, 8'($urandom), 1'($urandom),
              1'($urandom), 1'b0, '0);
    clock_bits(48, 1'($urandom_range(0, 1)));

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d result items from %0d working input items plus noise.",
             checked, work_items);
    $display("Transfers done: %0d, bytes received: %0d, send underruns: %0d.",
             done_cnt, rx_cnt, und_cnt);
    if (errors == 0) begin
      $display("three_wire_serial_transfer_engine_top regression: pass");
    end else begin
      $display("three_wire_serial_transfer_engine_top regression: fail");
    end
    $finish;
  end

endmodule
